[rtl/core/satpcr_pkg.sv]
`timescale 1ns / 1ps

package satpcr_pkg;

    localparam int MAX_VERTICES_DEF = 16;

    localparam int COORD_W = 32;
    localparam int N_W     = 33;
    localparam int U_W     = 18;
    localparam int UQ_W    = 17;
    localparam int PROD_W  = 50;
    localparam int PROJ_W  = 51;
    localparam int OV_W    = 52;
    localparam int OV16_W  = 36;
    localparam int MAG_W   = 53;
    localparam int RND_W   = 38;
    localparam int CEN_W   = 34;
    localparam int CPROD_W = 52;
    localparam int DOT_W   = 53;

    localparam logic [1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [1:0] CMD_RESOLVE = 2'd2;

    typedef struct packed {
        logic [1:0]                cmd;
        logic signed [COORD_W-1:0] vert_x;
        logic signed [COORD_W-1:0] vert_y;
    } item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] push_x;
        logic signed [COORD_W-1:0] push_y;
        logic                      collided;
        logic                      overflowed;
    } result_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] vert_y;
        logic signed [COORD_W-1:0] vert_x;
    } vertex_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] max_y;
    } box_t;

    typedef struct packed {
        logic signed [N_W-1:0] nx;
        logic signed [N_W-1:0] ny;
    } nrm_req_t;

    typedef struct packed {
        logic signed [U_W-1:0] ux;
        logic signed [U_W-1:0] uy;
    } nrm_rsp_t;

endpackage

[rtl/core/satpcr_unit_normal.sv]
`timescale 1ns / 1ps

module satpcr_unit_normal (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  satpcr_pkg::nrm_req_t req,
    output logic                done,
    output satpcr_pkg::nrm_rsp_t rsp
);

    localparam logic [2:0] N_IDLE = 3'd0;
    localparam logic [2:0] N_NORM = 3'd1;
    localparam logic [2:0] N_SQ0  = 3'd2;
    localparam logic [2:0] N_SQ1  = 3'd3;
    localparam logic [2:0] N_ROOT = 3'd4;
    localparam logic [2:0] N_DSET = 3'd5;
    localparam logic [2:0] N_DIV  = 3'd6;
    localparam logic [2:0] N_DONE = 3'd7;

    localparam int SQ_W  = 61;
    localparam int REM_W = 47;

    logic [2:0]  state_reg, state_next;
    logic        neg_x_reg, neg_x_next, neg_y_reg, neg_y_next;
    logic [31:0] ax_reg, ax_next, ay_reg, ay_next;
    logic [59:0] sq_reg, sq_next;
    logic [SQ_W-1:0] v_reg, v_next, r_reg, r_next, bit_reg, bit_next;
    logic [REM_W-1:0] rem_x_reg, rem_x_next, rem_y_reg, rem_y_next;
    logic [satpcr_pkg::UQ_W-1:0] q_x_reg, q_x_next, q_y_reg, q_y_next;
    logic [4:0]  cnt_reg, cnt_next;

    logic [satpcr_pkg::N_W-1:0] abs_x, abs_y;
    logic [31:0] mag;
    logic [59:0] sq_x, sq_y;
    logic [SQ_W:0] root_sum;
    logic [REM_W-1:0] trial;
    logic        bit_x, bit_y;

    always_comb
    begin
        abs_x = req.nx[satpcr_pkg::N_W-1] ? (~req.nx + 1'b1) : req.nx;
        abs_y = req.ny[satpcr_pkg::N_W-1] ? (~req.ny + 1'b1) : req.ny;
        mag = (ax_reg > ay_reg) ? ax_reg : ay_reg;
        sq_x = ax_reg[29:0] * ax_reg[29:0];
        sq_y = ay_reg[29:0] * ay_reg[29:0];
        root_sum = {1'b0, r_reg} + {1'b0, bit_reg};
        trial = {16'b0, r_reg[30:0]} << cnt_reg;
        bit_x = (rem_x_reg >= trial);
        bit_y = (rem_y_reg >= trial);

        state_next = state_reg;
        neg_x_next = neg_x_reg;
        neg_y_next = neg_y_reg;
        ax_next = ax_reg;
        ay_next = ay_reg;
        sq_next = sq_reg;
        v_next = v_reg;
        r_next = r_reg;
        bit_next = bit_reg;
        rem_x_next = rem_x_reg;
        rem_y_next = rem_y_reg;
        q_x_next = q_x_reg;
        q_y_next = q_y_reg;
        cnt_next = cnt_reg;

        unique case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    neg_x_next = req.nx[satpcr_pkg::N_W-1];
                    neg_y_next = req.ny[satpcr_pkg::N_W-1];
                    ax_next = abs_x[31:0];
                    ay_next = abs_y[31:0];
                    if (abs_x == '0 && abs_y == '0)
                    begin
                        q_x_next = '0;
                        q_y_next = '0;
                        state_next = N_DONE;
                    end
                    else
                    begin
                        state_next = N_NORM;
                    end
                end
            end
            N_NORM:
            begin
                if (mag[31:30] != 2'b00)
                begin
                    ax_next = ax_reg >> 1;
                    ay_next = ay_reg >> 1;
                end
                else if (!mag[29])
                begin
                    ax_next = ax_reg << 1;
                    ay_next = ay_reg << 1;
                end
                else
                begin
                    state_next = N_SQ0;
                end
            end
            N_SQ0:
            begin
                sq_next = sq_x;
                state_next = N_SQ1;
            end
            N_SQ1:
            begin
                v_next = {1'b0, sq_reg} + {1'b0, sq_y};
                r_next = '0;
                bit_next = {1'b1, {(SQ_W-1){1'b0}}};
                state_next = N_ROOT;
            end
            N_ROOT:
            begin
                if ({1'b0, v_reg} >= root_sum)
                begin
                    v_next = v_reg - root_sum[SQ_W-1:0];
                    r_next = (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_next = r_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    state_next = N_DSET;
                end
            end
            N_DSET:
            begin
                rem_x_next = {1'b0, ax_reg[29:0], 16'b0} + {17'b0, r_reg[30:1]};
                rem_y_next = {1'b0, ay_reg[29:0], 16'b0} + {17'b0, r_reg[30:1]};
                q_x_next = '0;
                q_y_next = '0;
                cnt_next = 5'd16;
                state_next = N_DIV;
            end
            N_DIV:
            begin
                if (bit_x)
                begin
                    rem_x_next = rem_x_reg - trial;
                end
                if (bit_y)
                begin
                    rem_y_next = rem_y_reg - trial;
                end
                q_x_next = {q_x_reg[satpcr_pkg::UQ_W-2:0], bit_x};
                q_y_next = {q_y_reg[satpcr_pkg::UQ_W-2:0], bit_y};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    state_next = N_DONE;
                end
            end
            N_DONE:
            begin
                state_next = N_IDLE;
            end
            default:
            begin
                state_next = N_IDLE;
            end
        endcase
    end

    assign done = (state_reg == N_DONE);
    assign rsp.ux = neg_x_reg ? (~{1'b0, q_x_reg} + 1'b1) : {1'b0, q_x_reg};
    assign rsp.uy = neg_y_reg ? (~{1'b0, q_y_reg} + 1'b1) : {1'b0, q_y_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_x_reg <= neg_x_next;
        neg_y_reg <= neg_y_next;
        ax_reg <= ax_next;
        ay_reg <= ay_next;
        sq_reg <= sq_next;
        v_reg <= v_next;
        r_reg <= r_next;
        bit_reg <= bit_next;
        rem_x_reg <= rem_x_next;
        rem_y_reg <= rem_y_next;
        q_x_reg <= q_x_next;
        q_y_reg <= q_y_next;
        cnt_reg <= cnt_next;
    end

endmodule

[rtl/core/sat_polygon_collision_resolve_unit.sv]
`timescale 1ns / 1ps

// Loads (cmd 0 and 1) are taken one per cycle while busy is low and keep busy low. A resolve
// beat (cmd 2) raises busy while the sequencer walks the two vertex memories: S_BB_RD and
// S_BB_ACC per vertex, then S_BB_CHK, for the bounding boxes; for every edge of A and of B
// the vertex reads S_E_RD0, S_E_RD1, S_E_DIF, then S_E_NRM in the unit-normal unit (normalize
// shifts, a 31-step square root and a 17-step divide; skipped for a zero-length edge), then
// S_PJ_RD, S_PJ_MUL, S_PJ_ACC per vertex of both polygons through the shared read address
// and S_AX_CHK for the axis check; last S_FIN0 to S_FIN5 form the push vector. An empty
// polygon, disjoint boxes or a separating axis end the walk early via S_ZERO. done is high
// for exactly one cycle with result, the receiver cannot stall it; both polygons are then empty.

module sat_polygon_collision_resolve_unit #(
    parameter int MAX_VERTICES = satpcr_pkg::MAX_VERTICES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  satpcr_pkg::item_t   item,
    output logic                done,
    output satpcr_pkg::result_t result
);

    localparam int ADDR_W = $clog2(MAX_VERTICES);
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_BB_RD  = 5'd1;
    localparam logic [4:0] S_BB_ACC = 5'd2;
    localparam logic [4:0] S_BB_CHK = 5'd3;
    localparam logic [4:0] S_E_RD0  = 5'd4;
    localparam logic [4:0] S_E_RD1  = 5'd5;
    localparam logic [4:0] S_E_DIF  = 5'd6;
    localparam logic [4:0] S_E_NRM  = 5'd7;
    localparam logic [4:0] S_PJ_RD  = 5'd8;
    localparam logic [4:0] S_PJ_MUL = 5'd9;
    localparam logic [4:0] S_PJ_ACC = 5'd10;
    localparam logic [4:0] S_AX_CHK = 5'd11;
    localparam logic [4:0] S_FIN0   = 5'd12;
    localparam logic [4:0] S_FIN1   = 5'd13;
    localparam logic [4:0] S_FIN2   = 5'd14;
    localparam logic [4:0] S_FIN3   = 5'd15;
    localparam logic [4:0] S_FIN4   = 5'd16;
    localparam logic [4:0] S_FIN5   = 5'd17;
    localparam logic [4:0] S_ZERO   = 5'd18;

    localparam int COORD_W = satpcr_pkg::COORD_W;
    localparam int N_W     = satpcr_pkg::N_W;
    localparam int U_W     = satpcr_pkg::U_W;
    localparam int UQ_W    = satpcr_pkg::UQ_W;
    localparam int PROD_W  = satpcr_pkg::PROD_W;
    localparam int PROJ_W  = satpcr_pkg::PROJ_W;
    localparam int OV_W    = satpcr_pkg::OV_W;
    localparam int OV16_W  = satpcr_pkg::OV16_W;
    localparam int MAG_W   = satpcr_pkg::MAG_W;
    localparam int RND_W   = satpcr_pkg::RND_W;
    localparam int CEN_W   = satpcr_pkg::CEN_W;
    localparam int CPROD_W = satpcr_pkg::CPROD_W;
    localparam int DOT_W   = satpcr_pkg::DOT_W;

    satpcr_pkg::vertex_t mem_a [MAX_VERTICES];
    satpcr_pkg::vertex_t mem_b [MAX_VERTICES];
    satpcr_pkg::vertex_t mem_a_q, mem_b_q, rd_vtx, wr_vtx;
    logic [ADDR_W-1:0] rd_addr;
    logic we_a, we_b;

    logic [4:0] state_reg, state_next;
    logic [CNT_W-1:0] count_a_reg, count_a_next, count_b_reg, count_b_next;
    logic ovf_reg, ovf_next;
    logic [ADDR_W-1:0] k_reg, k_next, i_reg, i_next;
    logic sel_reg, sel_next, pass_reg, pass_next, side_reg, side_next;
    logic done_reg, done_next;
    satpcr_pkg::result_t result_reg, result_next;

    satpcr_pkg::box_t box_a_reg, box_a_next, box_b_reg, box_b_next, box_cur, box_upd;
    logic signed [COORD_W-1:0] vi_x_reg, vi_x_next, vi_y_reg, vi_y_next;
    logic signed [U_W-1:0] ux_reg, ux_next, uy_reg, uy_next;
    logic signed [PROD_W-1:0] px_reg, px_next, py_reg, py_next, prod_x, prod_y;
    logic signed [PROJ_W-1:0] lo_p_reg, lo_p_next, hi_p_reg, hi_p_next;
    logic signed [PROJ_W-1:0] lo_q_reg, lo_q_next, hi_q_reg, hi_q_next;
    logic signed [PROJ_W-1:0] proj_d, hi_min, lo_max, lo_cur, hi_cur;
    logic signed [OV_W-1:0] ov, best_ov_reg, best_ov_next, keep_ov_reg, keep_ov_next;
    logic signed [OV_W-1:0] fin_ov;
    logic signed [U_W-1:0] best_ux_reg, best_ux_next, best_uy_reg, best_uy_next;
    logic signed [U_W-1:0] keep_ux_reg, keep_ux_next, keep_uy_reg, keep_uy_next;
    logic signed [U_W-1:0] upd_ux, upd_uy;
    logic signed [OV_W-1:0] upd_ov;
    logic [OV_W-1:0] ov_rnd;
    logic [OV16_W-1:0] ov16_reg, ov16_next;
    logic signed [CEN_W-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [CPROD_W-1:0] prod_cx, prod_cy;
    logic signed [DOT_W-1:0] dot_reg, dot_next;
    logic flip_reg, flip_next;
    logic [UQ_W-1:0] ux_mag, uy_mag;
    logic [MAG_W-1:0] mx_reg, mx_next, my_reg, my_next, mag_prod;
    logic [MAG_W:0] rnd_x_sum, rnd_y_sum;

    logic poly_sel;
    logic [CNT_W-1:0] n_cur, n_p;
    logic k_last, i_last, box_hit, sep;
    logic [ADDR_W-1:0] j_addr;

    satpcr_pkg::nrm_req_t nrm_req;
    satpcr_pkg::nrm_rsp_t nrm_rsp;
    logic nrm_start, nrm_done;

    function automatic logic [COORD_W-1:0] sat_push(input logic [RND_W-1:0] rnd,
                                                    input logic neg);
        logic [COORD_W-1:0] v;
        if (!neg)
        begin
            if (rnd > RND_W'({1'b0, {(COORD_W-1){1'b1}}}))
            begin
                v = {1'b0, {(COORD_W-1){1'b1}}};
            end
            else
            begin
                v = rnd[COORD_W-1:0];
            end
        end
        else
        begin
            if (rnd > RND_W'({1'b1, {(COORD_W-1){1'b0}}}))
            begin
                v = {1'b1, {(COORD_W-1){1'b0}}};
            end
            else
            begin
                v = ~rnd[COORD_W-1:0] + 1'b1;
            end
        end
        return v;
    endfunction

    satpcr_unit_normal u_normal (
        .clk   (clk),
        .rst_n (rst_n),
        .start (nrm_start),
        .req   (nrm_req),
        .done  (nrm_done),
        .rsp   (nrm_rsp)
    );

    always_comb
    begin
        wr_vtx.vert_x = item.vert_x;
        wr_vtx.vert_y = item.vert_y;
        we_a = (state_reg == S_IDLE) && start && (item.cmd == satpcr_pkg::CMD_LOAD_A)
               && (count_a_reg < CNT_W'(MAX_VERTICES));
        we_b = (state_reg == S_IDLE) && start && (item.cmd == satpcr_pkg::CMD_LOAD_B)
               && (count_b_reg < CNT_W'(MAX_VERTICES));

        n_p = pass_reg ? count_b_reg : count_a_reg;
        i_last = (({1'b0, i_reg} + 1'b1) == n_p);
        j_addr = i_last ? '0 : (i_reg + 1'b1);

        if (state_reg == S_BB_RD || state_reg == S_BB_ACC)
        begin
            poly_sel = sel_reg;
        end
        else if (state_reg == S_PJ_RD || state_reg == S_PJ_MUL || state_reg == S_PJ_ACC)
        begin
            poly_sel = pass_reg ^ side_reg;
        end
        else
        begin
            poly_sel = pass_reg;
        end
        n_cur = poly_sel ? count_b_reg : count_a_reg;
        k_last = (({1'b0, k_reg} + 1'b1) == n_cur);
        rd_vtx = poly_sel ? mem_b_q : mem_a_q;

        case (state_reg)
            S_E_RD0: rd_addr = i_reg;
            S_E_RD1: rd_addr = j_addr;
            default: rd_addr = k_reg;
        endcase

        nrm_start = (state_reg == S_E_DIF);
        nrm_req.nx = N_W'(vi_y_reg) - N_W'(rd_vtx.vert_y);
        nrm_req.ny = N_W'(rd_vtx.vert_x) - N_W'(vi_x_reg);

        prod_x = $signed(rd_vtx.vert_x) * ux_reg;
        prod_y = $signed(rd_vtx.vert_y) * uy_reg;
        proj_d = PROJ_W'(px_reg) + PROJ_W'(py_reg);

        box_cur = sel_reg ? box_b_reg : box_a_reg;
        box_upd = box_cur;
        if (k_reg == '0 || $signed(rd_vtx.vert_x) < box_cur.min_x)
        begin
            box_upd.min_x = rd_vtx.vert_x;
        end
        if (k_reg == '0 || $signed(rd_vtx.vert_x) > box_cur.max_x)
        begin
            box_upd.max_x = rd_vtx.vert_x;
        end
        if (k_reg == '0 || $signed(rd_vtx.vert_y) < box_cur.min_y)
        begin
            box_upd.min_y = rd_vtx.vert_y;
        end
        if (k_reg == '0 || $signed(rd_vtx.vert_y) > box_cur.max_y)
        begin
            box_upd.max_y = rd_vtx.vert_y;
        end
        box_hit = ($signed(box_a_reg.min_x) < $signed(box_b_reg.max_x))
                  && ($signed(box_a_reg.max_x) > $signed(box_b_reg.min_x))
                  && ($signed(box_a_reg.min_y) < $signed(box_b_reg.max_y))
                  && ($signed(box_a_reg.max_y) > $signed(box_b_reg.min_y));

        lo_cur = side_reg ? lo_q_reg : lo_p_reg;
        hi_cur = side_reg ? hi_q_reg : hi_p_reg;

        hi_min = (hi_p_reg < hi_q_reg) ? hi_p_reg : hi_q_reg;
        lo_max = (lo_p_reg > lo_q_reg) ? lo_p_reg : lo_q_reg;
        ov = OV_W'(hi_min) - OV_W'(lo_max);
        sep = (hi_q_reg < lo_p_reg) || (hi_p_reg < lo_q_reg);
        if (i_reg == '0 || ov < best_ov_reg)
        begin
            upd_ov = ov;
            upd_ux = ux_reg;
            upd_uy = uy_reg;
        end
        else
        begin
            upd_ov = best_ov_reg;
            upd_ux = best_ux_reg;
            upd_uy = best_uy_reg;
        end

        fin_ov = (keep_ov_reg < best_ov_reg) ? keep_ov_reg : best_ov_reg;
        ov_rnd = fin_ov + OV_W'(32768);

        prod_cx = cx_reg * best_ux_reg;
        prod_cy = cy_reg * best_uy_reg;
        ux_mag = best_ux_reg[U_W-1] ? UQ_W'(-best_ux_reg) : UQ_W'(best_ux_reg);
        uy_mag = best_uy_reg[U_W-1] ? UQ_W'(-best_uy_reg) : UQ_W'(best_uy_reg);
        mag_prod = ov16_reg * ((state_reg == S_FIN3) ? ux_mag : uy_mag);
        rnd_x_sum = {1'b0, mx_reg} + (MAG_W+1)'(32768);
        rnd_y_sum = {1'b0, my_reg} + (MAG_W+1)'(32768);

        state_next = state_reg;
        count_a_next = count_a_reg;
        count_b_next = count_b_reg;
        ovf_next = ovf_reg;
        k_next = k_reg;
        i_next = i_reg;
        sel_next = sel_reg;
        pass_next = pass_reg;
        side_next = side_reg;
        done_next = 1'b0;
        result_next = result_reg;
        box_a_next = box_a_reg;
        box_b_next = box_b_reg;
        vi_x_next = vi_x_reg;
        vi_y_next = vi_y_reg;
        ux_next = ux_reg;
        uy_next = uy_reg;
        px_next = px_reg;
        py_next = py_reg;
        lo_p_next = lo_p_reg;
        hi_p_next = hi_p_reg;
        lo_q_next = lo_q_reg;
        hi_q_next = hi_q_reg;
        best_ov_next = best_ov_reg;
        best_ux_next = best_ux_reg;
        best_uy_next = best_uy_reg;
        keep_ov_next = keep_ov_reg;
        keep_ux_next = keep_ux_reg;
        keep_uy_next = keep_uy_reg;
        ov16_next = ov16_reg;
        cx_next = cx_reg;
        cy_next = cy_reg;
        dot_next = dot_reg;
        flip_next = flip_reg;
        mx_next = mx_reg;
        my_next = my_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (item.cmd)
                        satpcr_pkg::CMD_LOAD_A:
                        begin
                            if (we_a)
                            begin
                                count_a_next = count_a_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        satpcr_pkg::CMD_LOAD_B:
                        begin
                            if (we_b)
                            begin
                                count_b_next = count_b_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        satpcr_pkg::CMD_RESOLVE:
                        begin
                            if (count_a_reg == '0 || count_b_reg == '0)
                            begin
                                state_next = S_ZERO;
                            end
                            else
                            begin
                                k_next = '0;
                                sel_next = 1'b0;
                                state_next = S_BB_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_BB_RD:
            begin
                state_next = S_BB_ACC;
            end
            S_BB_ACC:
            begin
                if (sel_reg)
                begin
                    box_b_next = box_upd;
                end
                else
                begin
                    box_a_next = box_upd;
                end
                if (k_last)
                begin
                    k_next = '0;
                    if (!sel_reg)
                    begin
                        sel_next = 1'b1;
                        state_next = S_BB_RD;
                    end
                    else
                    begin
                        state_next = S_BB_CHK;
                    end
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                    state_next = S_BB_RD;
                end
            end
            S_BB_CHK:
            begin
                pass_next = 1'b0;
                i_next = '0;
                state_next = box_hit ? S_E_RD0 : S_ZERO;
            end
            S_E_RD0:
            begin
                state_next = S_E_RD1;
            end
            S_E_RD1:
            begin
                vi_x_next = rd_vtx.vert_x;
                vi_y_next = rd_vtx.vert_y;
                state_next = S_E_DIF;
            end
            S_E_DIF:
            begin
                state_next = S_E_NRM;
            end
            S_E_NRM:
            begin
                if (nrm_done)
                begin
                    ux_next = nrm_rsp.ux;
                    uy_next = nrm_rsp.uy;
                    k_next = '0;
                    side_next = 1'b0;
                    state_next = S_PJ_RD;
                end
            end
            S_PJ_RD:
            begin
                state_next = S_PJ_MUL;
            end
            S_PJ_MUL:
            begin
                px_next = prod_x;
                py_next = prod_y;
                state_next = S_PJ_ACC;
            end
            S_PJ_ACC:
            begin
                if (k_reg == '0 || proj_d < lo_cur)
                begin
                    if (side_reg)
                    begin
                        lo_q_next = proj_d;
                    end
                    else
                    begin
                        lo_p_next = proj_d;
                    end
                end
                if (k_reg == '0 || proj_d > hi_cur)
                begin
                    if (side_reg)
                    begin
                        hi_q_next = proj_d;
                    end
                    else
                    begin
                        hi_p_next = proj_d;
                    end
                end
                if (k_last)
                begin
                    k_next = '0;
                    if (!side_reg)
                    begin
                        side_next = 1'b1;
                        state_next = S_PJ_RD;
                    end
                    else
                    begin
                        state_next = S_AX_CHK;
                    end
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                    state_next = S_PJ_RD;
                end
            end
            S_AX_CHK:
            begin
                best_ov_next = upd_ov;
                best_ux_next = upd_ux;
                best_uy_next = upd_uy;
                if (sep)
                begin
                    state_next = S_ZERO;
                end
                else if (i_last)
                begin
                    i_next = '0;
                    if (!pass_reg)
                    begin
                        keep_ov_next = upd_ov;
                        keep_ux_next = upd_ux;
                        keep_uy_next = upd_uy;
                        pass_next = 1'b1;
                        state_next = S_E_RD0;
                    end
                    else
                    begin
                        state_next = S_FIN0;
                    end
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                    state_next = S_E_RD0;
                end
            end
            S_FIN0:
            begin
                if (keep_ov_reg < best_ov_reg)
                begin
                    best_ux_next = keep_ux_reg;
                    best_uy_next = keep_uy_reg;
                end
                ov16_next = ov_rnd[OV_W-1:16];
                cx_next = (CEN_W'(box_a_reg.min_x) + CEN_W'(box_a_reg.max_x))
                          - (CEN_W'(box_b_reg.min_x) + CEN_W'(box_b_reg.max_x));
                cy_next = (CEN_W'(box_a_reg.min_y) + CEN_W'(box_a_reg.max_y))
                          - (CEN_W'(box_b_reg.min_y) + CEN_W'(box_b_reg.max_y));
                state_next = S_FIN1;
            end
            S_FIN1:
            begin
                dot_next = DOT_W'(prod_cx);
                state_next = S_FIN2;
            end
            S_FIN2:
            begin
                dot_next = dot_reg + DOT_W'(prod_cy);
                state_next = S_FIN3;
            end
            S_FIN3:
            begin
                flip_next = dot_reg[DOT_W-1];
                mx_next = mag_prod;
                state_next = S_FIN4;
            end
            S_FIN4:
            begin
                my_next = mag_prod;
                state_next = S_FIN5;
            end
            S_FIN5:
            begin
                result_next.push_x = sat_push(rnd_x_sum[MAG_W:16],
                                              best_ux_reg[U_W-1] ^ flip_reg);
                result_next.push_y = sat_push(rnd_y_sum[MAG_W:16],
                                              best_uy_reg[U_W-1] ^ flip_reg);
                result_next.collided = 1'b1;
                result_next.overflowed = ovf_reg;
                done_next = 1'b1;
                count_a_next = '0;
                count_b_next = '0;
                ovf_next = 1'b0;
                state_next = S_IDLE;
            end
            S_ZERO:
            begin
                result_next.push_x = '0;
                result_next.push_y = '0;
                result_next.collided = 1'b0;
                result_next.overflowed = ovf_reg;
                done_next = 1'b1;
                count_a_next = '0;
                count_b_next = '0;
                ovf_next = 1'b0;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign result = result_reg;

    always_ff @(posedge clk)
    begin
        if (we_a)
        begin
            mem_a[count_a_reg[ADDR_W-1:0]] <= wr_vtx;
        end
        if (we_b)
        begin
            mem_b[count_b_reg[ADDR_W-1:0]] <= wr_vtx;
        end
        mem_a_q <= mem_a[rd_addr];
        mem_b_q <= mem_b[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_a_reg <= '0;
            count_b_reg <= '0;
            ovf_reg <= 1'b0;
            k_reg <= '0;
            i_reg <= '0;
            sel_reg <= 1'b0;
            pass_reg <= 1'b0;
            side_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_a_reg <= count_a_next;
            count_b_reg <= count_b_next;
            ovf_reg <= ovf_next;
            k_reg <= k_next;
            i_reg <= i_next;
            sel_reg <= sel_next;
            pass_reg <= pass_next;
            side_reg <= side_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        box_a_reg <= box_a_next;
        box_b_reg <= box_b_next;
        vi_x_reg <= vi_x_next;
        vi_y_reg <= vi_y_next;
        ux_reg <= ux_next;
        uy_reg <= uy_next;
        px_reg <= px_next;
        py_reg <= py_next;
        lo_p_reg <= lo_p_next;
        hi_p_reg <= hi_p_next;
        lo_q_reg <= lo_q_next;
        hi_q_reg <= hi_q_next;
        best_ov_reg <= best_ov_next;
        best_ux_reg <= best_ux_next;
        best_uy_reg <= best_uy_next;
        keep_ov_reg <= keep_ov_next;
        keep_ux_reg <= keep_ux_next;
        keep_uy_reg <= keep_uy_next;
        ov16_reg <= ov16_next;
        cx_reg <= cx_next;
        cy_reg <= cy_next;
        dot_reg <= dot_next;
        flip_reg <= flip_next;
        mx_reg <= mx_next;
        my_reg <= my_next;
    end

endmodule

[sim/sat_polygon_collision_resolve_checker.sv]
`timescale 1ns / 1ps

module sat_polygon_collision_resolve_checker
    import satpcr_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    busy,
    input  item_t   item,
    input  logic    done,
    input  result_t result,
    output int      mismatches,
    output int      outstanding
);

    typedef struct {
        longint ux;
        longint uy;
        longint ov;
        bit     sep;
    } axis_t;

    vertex_t poly_a [MAX_VERTICES];
    vertex_t poly_b [MAX_VERTICES];
    int      verts_a;
    int      verts_b;
    bit      dropped;
    result_t expected_pushes [$];

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic void unit_axis(input longint nx, input longint ny,
                                      output longint ux, output longint uy);
        longint unsigned ax, ay, m, len, qx, qy;
        ax = (nx < 0) ? -nx : nx;
        ay = (ny < 0) ? -ny : ny;
        ux = 0;
        uy = 0;
        if (ax == 0 && ay == 0)
            return;
        m = (ax > ay) ? ax : ay;
        while (m >= (64'd1 << 30))
        begin
            ax >>= 1;
            ay >>= 1;
            m >>= 1;
        end
        while (m < (64'd1 << 29))
        begin
            ax <<= 1;
            ay <<= 1;
            m <<= 1;
        end
        len = isqrt(ax * ax + ay * ay);
        qx = ((ax << 16) + len / 2) / len;
        qy = ((ay << 16) + len / 2) / len;
        ux = (nx < 0) ? -longint'(qx) : longint'(qx);
        uy = (ny < 0) ? -longint'(qy) : longint'(qy);
    endfunction

    function automatic void span(input vertex_t p [MAX_VERTICES], input int n,
                                 input longint ux, input longint uy,
                                 output longint lo, output longint hi);
        longint d;
        lo = 64'sh7FFF_FFFF_FFFF_FFFF;
        hi = 64'sh8000_0000_0000_0000;
        for (int k = 0; k < n; k++)
        begin
            d = longint'(p[k].vert_x) * ux + longint'(p[k].vert_y) * uy;
            if (d < lo)
                lo = d;
            if (d > hi)
                hi = d;
        end
    endfunction

    function automatic axis_t least_overlap(input vertex_t p [MAX_VERTICES], input int np,
                                            input vertex_t q [MAX_VERTICES], input int nq);
        axis_t  r;
        int     j;
        longint dx, dy, ux, uy, lp, hp, lq, hq, ov;
        r.ux = 0;
        r.uy = 0;
        r.ov = 64'sh7FFF_FFFF_FFFF_FFFF;
        r.sep = 0;
        for (int i = 0; i < np; i++)
        begin
            j = (i + 1 == np) ? 0 : i + 1;
            dx = longint'(p[j].vert_x) - longint'(p[i].vert_x);
            dy = longint'(p[j].vert_y) - longint'(p[i].vert_y);
            unit_axis(-dy, dx, ux, uy);
            span(p, np, ux, uy, lp, hp);
            span(q, nq, ux, uy, lq, hq);
            ov = ((hp < hq) ? hp : hq) - ((lp > lq) ? lp : lq);
            if (ov < r.ov)
            begin
                r.ov = ov;
                r.ux = ux;
                r.uy = uy;
            end
            if (hq < lp || hp < lq)
            begin
                r.sep = 1;
                return r;
            end
        end
        return r;
    endfunction

    function automatic void bounds(input vertex_t p [MAX_VERTICES], input int n,
                                   output longint b [4]);
        b[0] = p[0].vert_x;
        b[1] = p[0].vert_x;
        b[2] = p[0].vert_y;
        b[3] = p[0].vert_y;
        for (int k = 1; k < n; k++)
        begin
            if (p[k].vert_x < b[0]) b[0] = p[k].vert_x;
            if (p[k].vert_x > b[1]) b[1] = p[k].vert_x;
            if (p[k].vert_y < b[2]) b[2] = p[k].vert_y;
            if (p[k].vert_y > b[3]) b[3] = p[k].vert_y;
        end
    endfunction

    function automatic logic [31:0] push_component(input longint unsigned ov16,
                                                   input longint u, input bit flip);
        longint unsigned mag;
        longint v;
        mag = (u < 0) ? -u : u;
        v = longint'((ov16 * mag + 64'd32768) >> 16);
        if (u < 0)
            v = -v;
        if (flip)
            v = -v;
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic result_t collision_predict();
        result_t         r;
        longint          ba [4];
        longint          bb [4];
        axis_t           p0, p1, best;
        longint          cx, cy;
        longint unsigned ov16;
        bit              flip;
        r = '0;
        r.overflowed = dropped;
        if (verts_a == 0 || verts_b == 0)
            return r;
        bounds(poly_a, verts_a, ba);
        bounds(poly_b, verts_b, bb);
        if (!(ba[0] < bb[1] && ba[1] > bb[0] && ba[2] < bb[3] && ba[3] > bb[2]))
            return r;
        p0 = least_overlap(poly_a, verts_a, poly_b, verts_b);
        if (p0.sep)
            return r;
        p1 = least_overlap(poly_b, verts_b, poly_a, verts_a);
        if (p1.sep)
            return r;
        best = (p0.ov < p1.ov) ? p0 : p1;
        ov16 = (longint'(best.ov) + 64'd32768) >> 16;
        cx = (ba[0] + ba[1]) - (bb[0] + bb[1]);
        cy = (ba[2] + ba[3]) - (bb[2] + bb[3]);
        flip = (cx * best.ux + cy * best.uy) < 0;
        r.push_x = push_component(ov16, best.ux, flip);
        r.push_y = push_component(ov16, best.uy, flip);
        r.collided = 1'b1;
        return r;
    endfunction

    assign outstanding = expected_pushes.size();

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        vertex_t v;
        if (!rst_n)
        begin
            verts_a = 0;
            verts_b = 0;
            dropped = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_pushes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: %p", result);
                end
                else
                begin
                    want = expected_pushes.pop_front();
                    if (result.push_x !== want.push_x || result.push_y !== want.push_y ||
                        result.collided !== want.collided ||
                        result.overflowed !== want.overflowed)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result mismatch: expected x=%0d y=%0d c=%b o=%b, ",
                                      "got x=%0d y=%0d c=%b o=%b"},
                                     want.push_x, want.push_y, want.collided, want.overflowed,
                                     result.push_x, result.push_y, result.collided,
                                     result.overflowed);
                    end
                end
            end
            if (start && !busy)
            begin
                v.vert_x = item.vert_x;
                v.vert_y = item.vert_y;
                case (item.cmd)
                    CMD_LOAD_A:
                        if (verts_a < MAX_VERTICES)
                        begin
                            poly_a[verts_a] = v;
                            verts_a = verts_a + 1;
                        end
                        else
                            dropped = 1;
                    CMD_LOAD_B:
                        if (verts_b < MAX_VERTICES)
                        begin
                            poly_b[verts_b] = v;
                            verts_b = verts_b + 1;
                        end
                        else
                            dropped = 1;
                    CMD_RESOLVE:
                    begin
                        expected_pushes.push_back(collision_predict());
                        verts_a = 0;
                        verts_b = 0;
                        dropped = 0;
                    end
                    default:
                        ;
                endcase
            end
        end
    end

    initial
        mismatches = 0;

endmodule

[sim/sat_polygon_collision_resolve_unit_test.sv]
`timescale 1ns / 1ps

module sat_polygon_collision_resolve_unit_test;
    import satpcr_pkg::*;

    localparam logic [1:0] CMD_NOP = 2'd3;
    localparam int ONE = 65536;
    localparam longint CYCLE_LIMIT = 8000000;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    item_t   item;
    logic    done;
    result_t result;
    int      mismatches;
    int      outstanding;
    int      sent;
    int      burst_left;
    longint  cycles;

    int dir_x [16] = '{1024, 946, 724, 392, 0, -392, -724, -946,
                       -1024, -946, -724, -392, 0, 392, 724, 946};
    int dir_y [16] = '{0, 392, 724, 946, 1024, 946, 724, 392,
                       0, -392, -724, -946, -1024, -946, -724, -392};

    sat_polygon_collision_resolve_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    sat_polygon_collision_resolve_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .done        (done),
        .result      (result),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 0;
        forever
            #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send(input logic [1:0] cmd, input logic [31:0] x, input logic [31:0] y);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        start <= 1'b1;
        item <= '{cmd: cmd, vert_x: x, vert_y: y};
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        sent++;
    endtask

    task automatic shape(input logic [1:0] cmd, input longint cx, input longint cy,
                         input longint r, input int k);
        int off;
        int d;
        off = $urandom_range(0, 15);
        for (int i = 0; i < k; i++)
        begin
            d = (off + i * 16 / k) % 16;
            send(cmd, 32'(cx + ((r * dir_x[d]) >>> 10)), 32'(cy + ((r * dir_y[d]) >>> 10)));
        end
    endtask

    task automatic square(input logic [1:0] cmd, input int x0, input int y0, input int s);
        send(cmd, x0, y0);
        send(cmd, x0 + s, y0);
        send(cmd, x0 + s, y0 + s);
        send(cmd, x0, y0 + s);
    endtask

    function automatic int sides();
        return ($urandom_range(0, 19) == 0) ? 16 : $urandom_range(1, 6);
    endfunction

    initial
    begin
        longint cx, cy, r;
        int     pick;
        int     waited;
        rst_n = 0;
        start = 0;
        item = '0;
        sent = 0;
        burst_left = 0;
        cycles = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send(CMD_NOP, 32'hFFFF_FFFF, 32'h8000_0000);
        send(CMD_RESOLVE, 0, 0);
        send(CMD_LOAD_A, 32'h7FFF_FFFF, 32'h8000_0000);
        send(CMD_RESOLVE, 0, 0);
        square(CMD_LOAD_A, 0, 0, 2 * ONE);
        square(CMD_LOAD_B, ONE, ONE / 2, 2 * ONE);
        send(CMD_RESOLVE, 0, 0);
        square(CMD_LOAD_A, 0, 0, ONE);
        square(CMD_LOAD_B, ONE, 0, ONE);
        send(CMD_RESOLVE, 0, 0);
        send(CMD_LOAD_A, 32'h8000_0000, 32'h8000_0000);
        send(CMD_LOAD_A, 32'h8000_0000, 32'h8000_0000);
        send(CMD_LOAD_A, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send(CMD_LOAD_B, 0, 0);
        send(CMD_LOAD_B, ONE, -ONE);
        send(CMD_LOAD_B, ONE, ONE);
        send(CMD_RESOLVE, 0, 0);
        for (int i = 0; i < 17; i++)
            send(CMD_LOAD_B, i * ONE, (i % 3) * ONE);
        send(CMD_LOAD_A, 0, 0);
        send(CMD_RESOLVE, 0, 0);

        while (sent < 2000)
        begin
            pick = $urandom_range(0, 99);
            cx = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
            cy = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
            r = $urandom_range(ONE / 4, 8 * ONE);
            if (pick < 70)
            begin
                shape(CMD_LOAD_A, cx, cy, r, sides());
                shape(CMD_LOAD_B, cx + $signed($urandom_range(0, 4 * r)) - 2 * r,
                      cy + $signed($urandom_range(0, 4 * r)) - 2 * r,
                      $urandom_range(ONE / 4, 8 * ONE), sides());
                if ($urandom_range(0, 9) == 0)
                    send(2'($urandom_range(0, 1)), $urandom, $urandom);
                send(CMD_RESOLVE, $urandom, $urandom);
            end
            else if (pick < 80)
            begin
                repeat ($urandom_range(1, 8))
                    send(2'($urandom_range(0, 3)), $urandom, $urandom);
                send(CMD_RESOLVE, $urandom, $urandom);
            end
            else if (pick < 88)
            begin
                repeat ($urandom_range(16, 19))
                    send(2'($urandom_range(0, 1)), $urandom, $urandom);
                send(CMD_RESOLVE, $urandom, $urandom);
            end
            else if (pick < 94)
            begin
                square(CMD_LOAD_A, int'(cx), int'(cy), int'(r));
                if ($urandom_range(0, 1))
                    square(CMD_LOAD_B, int'(cx + r), int'(cy + $urandom_range(0, r)), int'(r));
                else
                    square(CMD_LOAD_B, int'(cx + $urandom_range(0, r)), int'(cy - r), int'(r));
                send(CMD_RESOLVE, 0, 0);
            end
            else
            begin
                send(CMD_LOAD_A, 32'(cx), 32'(cy));
                send(CMD_LOAD_A, 32'(cx), 32'(cy));
                send(CMD_LOAD_A, 32'(cx + r), 32'(cy + r));
                shape(CMD_LOAD_B, cx, cy, r, 3);
                send(CMD_RESOLVE, 0, 0);
            end
        end
        start <= 1'b0;

        waited = 0;
        while (outstanding != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (400) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
